/* rtl/rtttl_pkg.sv */
// rtttl_pkg: shared types, constants and the note frequency table
// used by rtttl_token_parser and rtttl_note_parser_core, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtttl_pkg;

    localparam int unsigned TIMER_HZ_DEFAULT = 8000000;
    localparam int unsigned MS_PER_MIN       = 60000;

    localparam int unsigned LEN_W    = 7;
    localparam int unsigned OCT_W    = 3;
    localparam int unsigned TEMPO_W  = 10;
    localparam int unsigned PITCH_W  = 4;
    localparam int unsigned CMP_W    = 15;
    localparam int unsigned DUR_W    = 16;
    localparam int unsigned FREQ_W   = 12;

    localparam logic [LEN_W-1:0]   RST_LEN   = 7'd4;
    localparam logic [OCT_W-1:0]   RST_OCT   = 3'd6;
    localparam logic [TEMPO_W-1:0] RST_TEMPO = 10'd63;

    // register index within the apb map
    typedef enum logic [1:0] {
        REG_LENGTH = 2'd0,
        REG_OCTAVE = 2'd1,
        REG_TEMPO  = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    // what a token end hands to the arithmetic sequencer
    typedef struct packed {
        logic               valid;
        logic               end_only;
        logic               song_end;
        logic               rest;
        logic               dot;
        logic [PITCH_W-1:0] pitch;
        logic [OCT_W-1:0]   octave;
        logic [LEN_W-1:0]   length;
        logic [TEMPO_W-1:0] tempo;
    } emit_t;

    localparam logic [FREQ_W-1:0] FREQ_TAB [4][12] = '{
        '{12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
          12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494},
        '{12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
          12'd740,  12'd784,  12'd830,  12'd880,  12'd932,  12'd988},
        '{12'd1047, 12'd1109, 12'd1175, 12'd1244, 12'd1319, 12'd1397,
          12'd1480, 12'd1568, 12'd1660, 12'd1760, 12'd1865, 12'd1976},
        '{12'd2093, 12'd2218, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
          12'd2960, 12'd3136, 12'd3320, 12'd3520, 12'd3728, 12'd3951}
    };

endpackage

`default_nettype wire

/* rtl/rtttl_serial_div.sv */
// rtttl_serial_div: restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module rtttl_serial_div #(
    parameter int unsigned DW = 23,
    parameter int unsigned VW = 12
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DW-1:0]    quo_reg;
    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    dsr_reg;
    logic [VW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(DW);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/rtttl_token_parser.sv */
// rtttl_token_parser: header and note token state machine, one character per item
// depends on rtttl_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtttl_token_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [7:0]                    ch,
    input  wire logic [rtttl_pkg::LEN_W-1:0]   dflt_length,
    input  wire logic [rtttl_pkg::OCT_W-1:0]   dflt_octave,
    input  wire logic [rtttl_pkg::TEMPO_W-1:0] dflt_tempo,
    output rtttl_pkg::emit_t                   emit
);

    import rtttl_pkg::*;

    typedef enum logic [1:0] {
        PH_NAME     = 2'd0,
        PH_SETTINGS = 2'd1,
        PH_NOTES    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KEY_NONE   = 2'd0,
        KEY_LENGTH = 2'd1,
        KEY_OCTAVE = 2'd2,
        KEY_TEMPO  = 2'd3
    } key_t;

    localparam logic [PITCH_W-1:0] PITCH_B = 4'd11;

    function automatic logic [OCT_W-1:0] clamp_oct(input logic [OCT_W-1:0] o);
        logic [OCT_W-1:0] r;
        r = (o < 3'd4) ? 3'd4 : o;
        return r;
    endfunction

    phase_t             phase_reg;
    key_t               key_reg;
    logic [LEN_W-1:0]   slen_reg;
    logic [OCT_W-1:0]   soct_reg;
    logic [TEMPO_W-1:0] stempo_reg;
    logic [2:0]         step_reg;
    logic [LEN_W-1:0]   tlen_reg;
    logic [PITCH_W-1:0] tpitch_reg;
    logic [OCT_W-1:0]   toct_reg;
    logic               f_rest_reg, f_dot_reg, f_oct_reg, f_len_reg;

    logic               is_digit;
    logic [3:0]         dig;
    logic               is_letter;
    logic [PITCH_W-1:0] letter;
    logic               pending;
    logic [10:0]        len_acc;
    logic [13:0]        tempo_acc;
    logic [10:0]        tok_acc;

    assign is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
    assign dig       = is_digit ? ch[3:0] : 4'd0;
    assign pending   = (phase_reg == PH_NOTES) && (step_reg >= 3'd3);
    assign len_acc   = 11'(slen_reg) * 11'd10 + 11'(dig);
    assign tempo_acc = 14'(stempo_reg) * 14'd10 + 14'(dig);
    assign tok_acc   = 11'(tlen_reg) * 11'd10 + 11'(dig);

    always_comb begin
        is_letter = 1'b1;
        letter    = '0;
        case (ch)
            "c":     letter = 4'd0;
            "d":     letter = 4'd2;
            "e":     letter = 4'd4;
            "f":     letter = 4'd5;
            "g":     letter = 4'd7;
            "a":     letter = 4'd9;
            "b":     letter = 4'd11;
            "p":     letter = 4'd12;
            default: is_letter = 1'b0;
        endcase
    end

    // result request for the character at the input
    always_comb begin
        emit.valid    = (ch == 8'd0) || (pending && (ch == ","));
        emit.end_only = (ch == 8'd0) && !pending;
        emit.song_end = (ch == 8'd0);
        emit.rest     = f_rest_reg || emit.end_only;
        emit.dot      = f_dot_reg;
        emit.pitch    = emit.rest ? '0 : tpitch_reg;
        emit.octave   = clamp_oct((f_oct_reg && !emit.end_only) ? toct_reg : soct_reg);
        emit.length   = f_len_reg ? tlen_reg : slen_reg;
        emit.tempo    = stempo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_NAME;
            key_reg    <= KEY_NONE;
            slen_reg   <= RST_LEN;
            soct_reg   <= RST_OCT;
            stempo_reg <= RST_TEMPO;
            step_reg   <= '0;
            tlen_reg   <= '0;
            tpitch_reg <= '0;
            toct_reg   <= '0;
            f_rest_reg <= 1'b0;
            f_dot_reg  <= 1'b0;
            f_oct_reg  <= 1'b0;
            f_len_reg  <= 1'b0;
        end else if (accept) begin
            if (ch == 8'd0 || (phase_reg == PH_NOTES && ch == ",")) begin
                // end of token or song: start a fresh token
                step_reg   <= '0;
                tlen_reg   <= '0;
                tpitch_reg <= '0;
                toct_reg   <= '0;
                f_rest_reg <= 1'b0;
                f_dot_reg  <= 1'b0;
                f_oct_reg  <= 1'b0;
                f_len_reg  <= 1'b0;
                if (ch == 8'd0) begin
                    phase_reg <= PH_NAME;
                    key_reg   <= KEY_NONE;
                end
            end else begin
                case (phase_reg)
                    PH_NAME: begin
                        if (ch == ":") begin
                            phase_reg  <= PH_SETTINGS;
                            key_reg    <= KEY_NONE;
                            slen_reg   <= dflt_length;
                            soct_reg   <= dflt_octave;
                            stempo_reg <= dflt_tempo;
                        end
                    end
                    PH_SETTINGS: begin
                        if (ch == ":") begin
                            phase_reg  <= PH_NOTES;
                            key_reg    <= KEY_NONE;
                            step_reg   <= '0;
                            tlen_reg   <= '0;
                            tpitch_reg <= '0;
                            toct_reg   <= '0;
                            f_rest_reg <= 1'b0;
                            f_dot_reg  <= 1'b0;
                            f_oct_reg  <= 1'b0;
                            f_len_reg  <= 1'b0;
                        end else if (ch == ",") begin
                            key_reg <= KEY_NONE;
                        end else if (ch == "d") begin
                            key_reg  <= KEY_LENGTH;
                            slen_reg <= '0;
                        end else if (ch == "o") begin
                            key_reg  <= KEY_OCTAVE;
                            soct_reg <= '0;
                        end else if (ch == "b") begin
                            key_reg    <= KEY_TEMPO;
                            stempo_reg <= '0;
                        end else if (is_digit) begin
                            case (key_reg)
                                KEY_LENGTH: slen_reg <= (len_acc > 11'd99) ? 7'd99
                                                                           : len_acc[6:0];
                                KEY_OCTAVE: begin
                                    soct_reg <= (dig > 4'd7) ? 3'd7 : dig[2:0];
                                    key_reg  <= KEY_NONE;
                                end
                                KEY_TEMPO: stempo_reg <= (tempo_acc > 14'd999) ? 10'd999
                                                                               : tempo_acc[9:0];
                                default: ;
                            endcase
                        end
                    end
                    PH_NOTES: begin
                        case (step_reg)
                            3'd0, 3'd1, 3'd2: begin
                                if (is_digit && step_reg < 3'd2) begin
                                    tlen_reg  <= tok_acc[6:0];
                                    f_len_reg <= 1'b1;
                                    step_reg  <= step_reg + 3'd1;
                                end else if (is_letter) begin
                                    if (letter == 4'd12) begin
                                        f_rest_reg <= 1'b1;
                                        tpitch_reg <= '0;
                                    end else begin
                                        tpitch_reg <= letter;
                                    end
                                    step_reg <= 3'd3;
                                end
                            end
                            3'd3, 3'd4, 3'd5: begin
                                if (step_reg == 3'd3 && ch == "#") begin
                                    if (!f_rest_reg && tpitch_reg != PITCH_B) begin
                                        tpitch_reg <= tpitch_reg + 4'd1;
                                    end
                                    step_reg <= 3'd4;
                                end else if (step_reg != 3'd5 && ch == ".") begin
                                    f_dot_reg <= 1'b1;
                                    step_reg  <= 3'd5;
                                end else if (is_digit) begin
                                    toct_reg  <= (dig < 4'd4) ? 3'd4
                                               : (dig > 4'd7) ? 3'd7 : dig[2:0];
                                    f_oct_reg <= 1'b1;
                                    step_reg  <= 3'd6;
                                end
                            end
                            3'd6: begin
                                if (ch == ".") begin
                                    f_dot_reg <= 1'b1;
                                    step_reg  <= 3'd7;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: phase_reg <= PH_NAME;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/rtttl_note_parser_core.sv */
// rtttl_note_parser_core: top level, apb registers, division sequencer, result register
// depends on rtttl_pkg, rtttl_token_parser and rtttl_serial_div
`timescale 1ns / 1ps
`default_nettype none

// RTTTL ringtone parser. Characters arrive one per item on the s_ channel and
// each is taken as soon as it arrives while the parser is idle. An item that
// ends a note token (',' after a note letter, or the terminating zero) emits
// one result on the m_ channel: pitch, clamped octave, rest flag, tone timer
// compare value (TIMER_CLOCK_HZ / frequency - 1) and the duration in ms. The
// arithmetic runs on one shared bit-serial divider giving one quotient bit per
// cycle; a note needs up to three divisions (timer clock by frequency, 60000
// by tempo, then by length) on a divider DW bits wide, where DW is the bit
// width of TIMER_CLOCK_HZ but at least 16; rests skip the first division,
// and a zero tempo or length skips the last two. While that runs, and until
// the result moves into the output register, s_ready is low; a finished result
// sits in that register so ordinary characters keep flowing while the sink
// stalls. Defaults for length, octave and tempo sit at apb byte addresses 0,
// 4 and 8 and should only be written while idle.

module rtttl_note_parser_core #(
    parameter int unsigned TIMER_CLOCK_HZ = rtttl_pkg::TIMER_HZ_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_ch,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rtttl_pkg::PITCH_W-1:0]      m_pitch,
    output logic [rtttl_pkg::OCT_W-1:0]        m_note_octave,
    output logic                               m_is_rest,
    output logic [rtttl_pkg::CMP_W-1:0]        m_compare_value,
    output logic [rtttl_pkg::DUR_W-1:0]        m_duration_ms,
    output logic                               m_bad_value,
    output logic                               m_song_end,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import rtttl_pkg::*;

    // dividend must hold the timer clock and the ms-per-minute constant
    localparam int unsigned CLK_BITS = $clog2(TIMER_CLOCK_HZ + 1);
    localparam int unsigned DW       = (CLK_BITS > 16) ? CLK_BITS : 16;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_FREQ  = 3'd1,
        ST_TEMPO = 3'd2,
        ST_LEN   = 3'd3,
        ST_HOLD  = 3'd4
    } state_t;

    // ---- configuration registers ----
    logic [LEN_W-1:0]   dlen_reg;
    logic [OCT_W-1:0]   doct_reg;
    logic [TEMPO_W-1:0] dtempo_reg;
    reg_idx_t           reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dlen_reg   <= RST_LEN;
            doct_reg   <= RST_OCT;
            dtempo_reg <= RST_TEMPO;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LENGTH: dlen_reg   <= pwdata[LEN_W-1:0];
                REG_OCTAVE: doct_reg   <= pwdata[OCT_W-1:0];
                REG_TEMPO:  dtempo_reg <= pwdata[TEMPO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LENGTH: prdata = 32'(dlen_reg);
            REG_OCTAVE: prdata = 32'(doct_reg);
            REG_TEMPO:  prdata = 32'(dtempo_reg);
            default:    prdata = '0;
        endcase
    end

    // ---- character parser ----
    emit_t emit;
    logic  s_accept;

    assign s_accept = s_valid && s_ready;

    rtttl_token_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .ch          (s_ch),
        .dflt_length (dlen_reg),
        .dflt_octave (doct_reg),
        .dflt_tempo  (dtempo_reg),
        .emit        (emit)
    );

    // ---- shared divider ----
    logic              div_start_reg;
    logic [DW-1:0]     div_a_reg;
    logic [FREQ_W-1:0] div_b_reg;
    logic              div_done;
    logic [DW-1:0]     div_q;

    rtttl_serial_div #(
        .DW (DW),
        .VW (FREQ_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---- division sequencer and result register ----
    state_t             state_reg;
    emit_t              job_reg;
    logic               bad_reg;
    logic [CMP_W-1:0]   cmp_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic               emit_bad;
    logic               div_go;
    logic [DW-1:0]      q_dec;
    logic [CMP_W-1:0]   cmp_sat;
    logic [17:0]        dur_x4;
    logic [19:0]        dur_x6;
    logic [18:0]        dur_scaled;
    logic [DUR_W-1:0]   dur_sat;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid || m_ready;
    assign emit_bad = (emit.tempo == '0) || (emit.length == '0);

    // a division starts the cycle after its operands are loaded
    always_comb begin
        case (state_reg)
            ST_IDLE:  div_go = s_accept && emit.valid && !emit.end_only &&
                               (!emit.rest || !emit_bad);
            ST_FREQ:  div_go = div_done && !bad_reg;
            ST_TEMPO: div_go = div_done;
            default:  div_go = 1'b0;
        endcase
    end

    // compare value: quotient minus one, saturated to the timer width
    assign q_dec   = (div_q == '0) ? '0 : div_q - DW'(1);
    assign cmp_sat = (q_dec > DW'({CMP_W{1'b1}})) ? {CMP_W{1'b1}} : q_dec[CMP_W-1:0];

    // duration: times four, then times one and a half when dotted
    assign dur_x4     = {div_q[15:0], 2'b00};
    assign dur_x6     = {2'b00, dur_x4} + {1'b0, dur_x4, 1'b0};
    assign dur_scaled = job_reg.dot ? dur_x6[19:1] : {1'b0, dur_x4};
    assign dur_sat    = (dur_scaled > 19'(16'hffff)) ? 16'hffff : dur_scaled[DUR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_valid       <= 1'b0;
        end else begin
            div_start_reg <= div_go;
            // result register: loaded from the hold state, cleared once taken
            if (state_reg == ST_HOLD && out_free) begin
                m_valid <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && emit.valid) begin
                        job_reg <= emit;
                        bad_reg <= emit_bad && !emit.end_only;
                        cmp_reg <= '0;
                        dur_reg <= '0;
                        if (emit.end_only) begin
                            state_reg <= ST_HOLD;
                        end else if (!emit.rest) begin
                            div_a_reg <= DW'(TIMER_CLOCK_HZ);
                            div_b_reg <= FREQ_TAB[emit.octave[1:0]][emit.pitch];
                            state_reg <= ST_FREQ;
                        end else if (!emit_bad) begin
                            div_a_reg <= DW'(MS_PER_MIN);
                            div_b_reg <= FREQ_W'(emit.tempo);
                            state_reg <= ST_TEMPO;
                        end else begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_FREQ: begin
                    if (div_done) begin
                        cmp_reg <= cmp_sat;
                        if (!bad_reg) begin
                            div_a_reg <= DW'(MS_PER_MIN);
                            div_b_reg <= FREQ_W'(job_reg.tempo);
                            state_reg <= ST_TEMPO;
                        end else begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_TEMPO: begin
                    if (div_done) begin
                        div_a_reg <= div_q;
                        div_b_reg <= FREQ_W'(job_reg.length);
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    if (div_done) begin
                        dur_reg   <= dur_sat;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    // wait for the result register to drain
                    if (out_free) begin
                        m_pitch         <= job_reg.pitch;
                        m_note_octave   <= job_reg.octave;
                        m_is_rest       <= job_reg.rest;
                        m_compare_value <= cmp_reg;
                        m_duration_ms   <= dur_reg;
                        m_bad_value     <= bad_reg;
                        m_song_end      <= job_reg.song_end;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
